>>> hw/rtl/rtcc_pkg.sv
// Shared constants and types for the roots-to-Chebyshev coefficient builder.
`timescale 1ns / 1ps

package rtcc_pkg;

   localparam int MAX_ROOTS = 16;
   localparam int FRAC_BITS = 30;

   localparam int ROOT_W    = 32;
   localparam int ROOT_FRAC = 30;
   localparam int COEF_W    = 64;
   localparam int HALF_W    = COEF_W / 2;
   localparam int PROD_W    = ROOT_W + COEF_W;
   localparam int SUM_W     = COEF_W + 3;

   localparam int NCOEF = MAX_ROOTS + 1;
   localparam int RS_W  = $clog2(MAX_ROOTS + 1);
   localparam int CNT_W = $clog2(NCOEF + 1);

   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

   // per-cycle command broadcast along the cell row
   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_MUL_LO = 3'd2,
      OP_MUL_HI = 3'd3,
      OP_TERM   = 3'd4,
      OP_SUM    = 3'd5,
      OP_SHIFT  = 3'd6
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [ROOT_W-1:0] rmag;
      logic              rneg;
   } cell_ctrl_type;

   typedef struct packed {
      logic sat;
   } cell_stat_type;

endpackage

>>> hw/rtl/rtcc_if.sv
// Valid/ready channel interfaces for roots in and coefficients out.
`timescale 1ns / 1ps

interface rtcc_req_if import rtcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ROOT_W-1:0] root_value;
   logic                     last_root;

   modport source (output valid, output root_value, output last_root, input ready);
   modport sink   (input valid, input root_value, input last_root, output ready);
endinterface

interface rtcc_rsp_if import rtcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coef_value;
   logic                     coef_last;
   logic                     overflow;

   modport source (output valid, output coef_value, output coef_last, output overflow,
                   input ready);
   modport sink   (input valid, input coef_value, input coef_last, input overflow,
                   output ready);
endinterface

>>> hw/rtl/roots_to_chebyshev_coeffs.sv
// Top level: root intake, cell-row sequencer and coefficient readout.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid / ready    root_value (Q1.30), last_root
//   rsp_chan  out  valid / ready    coef_value (Q33.30), coef_last, overflow
//
// First root of a set loads straight into the cell row; a dropped root also ends at intake.
// Every later root goes through intake, then each cell's one 32x32
// multiplier runs over the low and high halves of |c|, then rounding, then the
// neighbor sum.
// A last root is followed by n+1 coefficients for n roots held, one per cycle, shifted out of the
// cell row through cell 0; rsp_chan.ready low holds the row in place.
// Synchronous reset clears the sequencer, root count and overflow flag.
`timescale 1ns / 1ps

module roots_to_chebyshev_coeffs import rtcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rtcc_req_if.sink   req_chan,
   rtcc_rsp_if.source rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL_LO = 6'b000010,
      ST_MUL_HI = 6'b000100,
      ST_TERM   = 6'b001000,
      ST_SUM    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [RS_W-1:0]   roots_seen_ff, roots_seen_in;
   logic              sticky_ff, sticky_in;
   logic [CNT_W-1:0]  emit_left_ff, emit_left_in;
   logic [ROOT_W-1:0] rmag_ff, rmag_in;
   logic              rneg_ff, rneg_in;
   logic              last_ff, last_in;

   cell_ctrl_type            ctrl;
   cell_op_type              op;
   cell_stat_type            stat_vec [NCOEF];
   logic signed [COEF_W-1:0] coef_vec [NCOEF];
   logic                     any_sat;
   logic                     req_take, rsp_take;
   logic                     in_neg;
   logic [ROOT_W-1:0]        in_mag;
   logic [COEF_W-1:0]        first_mag, first_coef;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   assign in_neg = req_chan.root_value[ROOT_W-1];
   assign in_mag = in_neg ? (ROOT_W'(0) - ROOT_W'(req_chan.root_value))
                          : ROOT_W'(req_chan.root_value);

   // -r moved from the root's fraction width to the coefficient's
   generate
      if (FRAC_BITS >= ROOT_FRAC) begin : g_frac_up
         assign first_mag = COEF_W'(in_mag) << (FRAC_BITS - ROOT_FRAC);
      end else begin : g_frac_down
         assign first_mag = (COEF_W'(in_mag) + (COEF_W'(1) << (ROOT_FRAC - FRAC_BITS - 1)))
                            >> (ROOT_FRAC - FRAC_BITS);
      end
   endgenerate
   assign first_coef = in_neg ? first_mag : (COEF_W'(0) - first_mag);

   always_comb begin
      any_sat = 1'b0;
      for (int i = 0; i < NCOEF; i++) begin
         any_sat = any_sat | stat_vec[i].sat;
      end
   end

   always_comb begin
      state_in      = state_ff;
      roots_seen_in = roots_seen_ff;
      sticky_in     = sticky_ff;
      emit_left_in  = emit_left_ff;
      rmag_in       = rmag_ff;
      rneg_in       = rneg_ff;
      last_in       = last_ff;
      op            = OP_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rmag_in = in_mag;
               rneg_in = in_neg;
               last_in = req_chan.last_root;
               if (roots_seen_ff == '0) begin
                  op            = OP_LOAD;
                  roots_seen_in = RS_W'(1);
                  if (req_chan.last_root) begin
                     state_in     = ST_EMIT;
                     emit_left_in = CNT_W'(2);
                  end
               end else if (roots_seen_ff < RS_W'(MAX_ROOTS)) begin
                  state_in = ST_MUL_LO;
               end else begin
                  // root beyond capacity is dropped
                  sticky_in = 1'b1;
                  if (req_chan.last_root) begin
                     state_in     = ST_EMIT;
                     emit_left_in = CNT_W'(MAX_ROOTS + 1);
                  end
               end
            end
         end
         ST_MUL_LO: begin
            op       = OP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            op       = OP_MUL_HI;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            op       = OP_TERM;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            op            = OP_SUM;
            roots_seen_in = roots_seen_ff + RS_W'(1);
            sticky_in     = sticky_ff | any_sat;
            if (last_ff) begin
               state_in     = ST_EMIT;
               emit_left_in = CNT_W'(roots_seen_ff) + CNT_W'(2);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               op           = OP_SHIFT;
               emit_left_in = emit_left_ff - CNT_W'(1);
               if (emit_left_ff == CNT_W'(1)) begin
                  state_in      = ST_IDLE;
                  roots_seen_in = '0;
                  sticky_in     = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         roots_seen_ff <= '0;
         sticky_ff     <= 1'b0;
         emit_left_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         roots_seen_ff <= roots_seen_in;
         sticky_ff     <= sticky_in;
         emit_left_ff  <= emit_left_in;
      end
      rmag_ff <= rmag_in;
      rneg_ff <= rneg_in;
      last_ff <= last_in;
   end

   assign ctrl.op   = op;
   assign ctrl.rmag = rmag_ff;
   assign ctrl.rneg = rneg_ff;

   generate
      for (genvar l = 0; l < NCOEF; l++) begin : g_cell
         logic signed [COEF_W-1:0] left_value, right_value, extra_value, load_value;

         assign left_value  = (l == 0) ? '0 : coef_vec[(l == 0) ? 0 : l - 1];
         assign right_value = (l == NCOEF - 1) ? '0 : coef_vec[(l == NCOEF - 1) ? l : l + 1];
         // 2x*T0 = 2*T1 puts c[0] into c[1] twice
         assign extra_value = (l == 1) ? coef_vec[0] : '0;
         assign load_value  = (l == 0) ? first_coef : ((l == 1) ? COEF_ONE : '0);

         rtcc_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .left_value  (left_value),
            .right_value (right_value),
            .extra_value (extra_value),
            .load_value  (load_value),
            .coef_value  (coef_vec[l]),
            .stat        (stat_vec[l])
         );
      end
   endgenerate

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = (state_ff == ST_EMIT);
   assign rsp_chan.coef_value = coef_vec[0];
   assign rsp_chan.coef_last  = (emit_left_ff == CNT_W'(1));
   assign rsp_chan.overflow   = sticky_ff;

`ifndef SYNTHESIS
   a_no_intake_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("root intake open during readout");

   a_emit_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (emit_left_ff != '0))
      else $error("readout with no coefficients left");

   a_root_count_bound: assert property (@(posedge clock) disable iff (reset)
      roots_seen_ff <= RS_W'(MAX_ROOTS))
      else $error("root count beyond capacity");

   a_sat_sets_sticky: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SUM) && any_sat) |=> sticky_ff)
      else $error("saturation not recorded");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_chan.coef_last) |=> ((state_ff == ST_IDLE) && (roots_seen_ff == '0)
                                             && !sticky_ff))
      else $error("run did not close after final coefficient");
`endif

endmodule

>>> hw/rtl/rtcc_cell.sv
// One coefficient cell: holds c[l], forms -2r*c[l] and sums with its neighbors.
`timescale 1ns / 1ps

module rtcc_cell import rtcc_pkg::*; (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [COEF_W-1:0] left_value,
   input  logic signed [COEF_W-1:0] right_value,
   input  logic signed [COEF_W-1:0] extra_value,
   input  logic signed [COEF_W-1:0] load_value,
   output logic signed [COEF_W-1:0] coef_value,
   output cell_stat_type            stat
);

   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic [COEF_W-1:0]        prod_lo_ff, prod_lo_in;
   logic [COEF_W-1:0]        prod_hi_ff, prod_hi_in;
   logic [COEF_W-1:0]        term_ff, term_in;
   logic                     term_sat_ff, term_sat_in;

   logic              cneg, tneg, big, q_sat, sum_sat;
   logic [COEF_W-1:0] cmag, q, lim, qs;
   logic [HALF_W-1:0] mul_half;
   logic [COEF_W-1:0] prod;
   logic [PROD_W-1:0] full;
   logic [SUM_W-1:0]  sum;

   assign cneg     = coef_ff[COEF_W-1];
   assign cmag     = cneg ? (COEF_W'(0) - coef_ff) : coef_ff;
   assign mul_half = (ctrl.op == OP_MUL_HI) ? cmag[COEF_W-1:HALF_W] : cmag[HALF_W-1:0];
   // single 32x32 multiplier, used for the low then the high half of |c|
   assign prod     = COEF_W'(ctrl.rmag) * COEF_W'(mul_half);

   // 2r*c rounded to nearest, ties away from zero, on the magnitude
   assign full  = PROD_W'(prod_lo_ff) + {prod_hi_ff, {HALF_W{1'b0}}}
                + (PROD_W'(1) << (ROOT_FRAC - 2));
   assign big   = |full[PROD_W-1:ROOT_FRAC+COEF_W-1];
   assign q     = full[ROOT_FRAC+COEF_W-2:ROOT_FRAC-1];
   assign tneg  = (ctrl.rneg == cneg);
   assign lim   = tneg ? COEF_MIN : COEF_MAX;
   assign q_sat = big || (q > lim);
   assign qs    = q_sat ? lim : q;

   assign sum = {{3{left_value[COEF_W-1]}}, left_value}
              + {{3{right_value[COEF_W-1]}}, right_value}
              + {{3{extra_value[COEF_W-1]}}, extra_value}
              + {{3{term_ff[COEF_W-1]}}, term_ff};
   assign sum_sat = !((sum[SUM_W-1:COEF_W-1] == '0) || (sum[SUM_W-1:COEF_W-1] == '1));

   always_comb begin
      coef_in     = coef_ff;
      prod_lo_in  = prod_lo_ff;
      prod_hi_in  = prod_hi_ff;
      term_in     = term_ff;
      term_sat_in = term_sat_ff;
      case (ctrl.op)
         OP_LOAD:   coef_in = load_value;
         OP_MUL_LO: prod_lo_in = prod;
         OP_MUL_HI: prod_hi_in = prod;
         OP_TERM: begin
            term_in     = tneg ? (COEF_W'(0) - qs) : qs;
            term_sat_in = q_sat;
         end
         OP_SUM: begin
            if (sum_sat) begin
               coef_in = sum[SUM_W-1] ? COEF_MIN : COEF_MAX;
            end else begin
               coef_in = sum[COEF_W-1:0];
            end
         end
         OP_SHIFT:  coef_in = right_value;
         default:   coef_in = coef_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      coef_ff     <= coef_in;
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      term_ff     <= term_in;
      term_sat_ff <= term_sat_in;
   end

   assign coef_value = coef_ff;
   assign stat.sat   = (ctrl.op == OP_SUM) && (sum_sat || term_sat_ff);

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the roots-to-Chebyshev coefficient builder.
`timescale 1ns / 1ps

module testbench;
   import rtcc_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_ROOTS = 170;

   typedef struct packed {
      logic [COEF_W-1:0] value;
      logic              is_last;
      logic              ovf;
   } coef_rec_type;

   // one directed row: reps copies of a root, the mark only on the final copy
   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              is_last;
      logic [4:0]        reps;
      logic              typed;
      logic [COEF_W-1:0] c0;
      logic [COEF_W-1:0] c1;
   } root_row_type;

   localparam int NUM_ROWS = 7;
   localparam root_row_type ROOT_TABLE [NUM_ROWS] = '{
      '{32'h0000_0000, 1'b1, 5'd1,  1'b1, 64'h0,                   COEF_ONE},
      '{32'h8000_0000, 1'b1, 5'd1,  1'b1, 64'h0000_0000_8000_0000, COEF_ONE},
      '{32'h7FFF_FFFF, 1'b1, 5'd1,  1'b1, 64'hFFFF_FFFF_8000_0001, COEF_ONE},
      '{32'h0000_0001, 1'b1, 5'd1,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, COEF_ONE},
      '{32'h7FFF_FFFF, 1'b0, 5'd1,  1'b0, 64'h0,                   64'h0},
      '{32'hC000_0000, 1'b1, 5'd3,  1'b0, 64'h0,                   64'h0},
      // full row of -2 roots saturates, then one excess root carries the mark
      '{32'h8000_0000, 1'b1, 5'd17, 1'b0, 64'h0,                   64'h0}
   };

   logic clock;
   logic reset;

   rtcc_req_if req_chan ();
   rtcc_rsp_if rsp_chan ();

   roots_to_chebyshev_coeffs dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   int send_idle_pct = 7;
   int recv_idle_pct = 53;
   int mismatches    = 0;
   int roots_sent    = 0;
   int stall_cycles  = 0;

   coef_rec_type coef_expect_q [$];

   // predictor state
   logic [COEF_W-1:0] cheb_coef [NCOEF];
   int                roots_held = 0;
   bit                sat_flag   = 1'b0;

   // -(2*r*c), rounded to nearest with ties away from zero, saturated
   function automatic logic [COEF_W-1:0] minus_two_r_c(logic [ROOT_W-1:0] rmag, logic rneg,
                                                        logic [COEF_W-1:0] c);
      logic              cneg;
      logic [COEF_W-1:0] cmag;
      logic [PROD_W:0]   prod;
      logic [PROD_W:0]   q;
      logic              tneg;
      logic [COEF_W-1:0] lim;
      cneg = c[COEF_W-1];
      cmag = cneg ? (COEF_W'(0) - c) : c;
      prod = (PROD_W+1)'(rmag) * (PROD_W+1)'(cmag);
      q    = (prod + ((PROD_W+1)'(1) << (ROOT_FRAC - 2))) >> (ROOT_FRAC - 1);
      tneg = (rneg == cneg);
      lim  = tneg ? COEF_MIN : COEF_MAX;
      if (q > (PROD_W+1)'(lim)) begin
         sat_flag = 1'b1;
         q = (PROD_W+1)'(lim);
      end
      return tneg ? (COEF_W'(0) - q[COEF_W-1:0]) : q[COEF_W-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] widen(logic [COEF_W-1:0] v);
      return {{(SUM_W-COEF_W){v[COEF_W-1]}}, v};
   endfunction

   function automatic logic [COEF_W-1:0] clamp_sum(logic signed [SUM_W-1:0] s);
      if (s > widen(COEF_MAX)) begin
         sat_flag = 1'b1;
         return COEF_MAX;
      end
      if (s < widen(COEF_MIN)) begin
         sat_flag = 1'b1;
         return COEF_MIN;
      end
      return s[COEF_W-1:0];
   endfunction

   // advance the series by one root; queue the coefficients on a marked root
   function automatic void absorb_root(logic [ROOT_W-1:0] root, logic is_last, bit record);
      logic              rneg;
      logic [ROOT_W-1:0] rmag;
      logic [COEF_W-1:0] m;
      logic [COEF_W-1:0] prev [NCOEF];
      logic signed [SUM_W-1:0] acc;
      coef_rec_type      rec;
      rneg = root[ROOT_W-1];
      rmag = rneg ? (ROOT_W'(0) - root) : root;
      if (roots_held == 0) begin
         foreach (cheb_coef[l]) cheb_coef[l] = '0;
         if (FRAC_BITS >= ROOT_FRAC)
            m = COEF_W'(rmag) << (FRAC_BITS - ROOT_FRAC);
         else
            m = (COEF_W'(rmag) + (COEF_W'(1) << (ROOT_FRAC - FRAC_BITS - 1)))
                >> (ROOT_FRAC - FRAC_BITS);
         cheb_coef[0] = rneg ? m : (COEF_W'(0) - m);
         cheb_coef[1] = COEF_ONE;
         roots_held = 1;
      end else if (roots_held < MAX_ROOTS) begin
         prev = cheb_coef;
         for (int l = 0; l < NCOEF; l++) begin
            acc = widen(minus_two_r_c(rmag, rneg, prev[l]));
            if (l >= 1)        acc = acc + widen(prev[l-1]);
            if (l == 1)        acc = acc + widen(prev[0]);
            if (l + 1 < NCOEF) acc = acc + widen(prev[l+1]);
            cheb_coef[l] = clamp_sum(acc);
         end
         roots_held++;
      end else begin
         // row is full: root dropped
         sat_flag = 1'b1;
      end
      if (is_last) begin
         for (int k = 0; k <= roots_held; k++) begin
            rec.value   = cheb_coef[k];
            rec.is_last = (k == roots_held);
            rec.ovf     = sat_flag;
            if (record) coef_expect_q.push_back(rec);
         end
         foreach (cheb_coef[l]) cheb_coef[l] = '0;
         roots_held = 0;
         sat_flag   = 1'b0;
      end
   endfunction

   function automatic void check_field(string name, logic [COEF_W-1:0] want,
                                       logic [COEF_W-1:0] got);
      if (got !== want) begin
         if (mismatches < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
         mismatches++;
      end
   endfunction

   // result side: check accepted transactions, then pick the next ready
   always @(posedge clock) begin : coef_check
      coef_rec_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (coef_expect_q.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected coefficient %h", $realtime, rsp_chan.coef_value);
            mismatches++;
         end else begin
            want = coef_expect_q.pop_front();
            check_field("coef_value", want.value, rsp_chan.coef_value);
            check_field("coef_last", COEF_W'(want.is_last), COEF_W'(rsp_chan.coef_last));
            check_field("overflow", COEF_W'(want.ovf), COEF_W'(rsp_chan.overflow));
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic send_root(input logic [ROOT_W-1:0] root, input logic is_last,
                            input bit record);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.root_value <= root;
      req_chan.last_root  <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      absorb_root(root, is_last, record);
      roots_sent++;
   endtask

   task automatic drain_expected();
      while (coef_expect_q.size() != 0) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [ROOT_W-1:0] pick_root();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom;
         5: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         // |r| <= 0.5 keeps long sets away from saturation
         default: return $urandom_range(32'h4000_0000) - 32'h2000_0000;
      endcase
   endfunction

   function automatic int pick_set_len();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(5, 1);
      if (roll < 90) return $urandom_range(16, 6);
      return $urandom_range(MAX_ROOTS + 3, MAX_ROOTS);
   endfunction

   initial begin : stimulus
      root_row_type row;
      coef_rec_type rec;
      int           set_len;
      int           phase_start;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.root_value = '0;
      req_chan.last_root  = 1'b0;
      rsp_chan.ready      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (ROOT_TABLE[i]) begin
         row = ROOT_TABLE[i];
         for (int k = 1; k <= row.reps; k++)
            send_root(row.root, (k == row.reps) ? row.is_last : 1'b0, !row.typed);
         if (row.typed) begin
            rec = '{value: row.c0, is_last: 1'b0, ovf: 1'b0};
            coef_expect_q.push_back(rec);
            rec = '{value: row.c1, is_last: 1'b1, ovf: 1'b0};
            coef_expect_q.push_back(rec);
         end
      end
      drain_expected();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 7;  recv_idle_pct = 53; end
            1: begin send_idle_pct = 53; recv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         phase_start = roots_sent;
         while (roots_sent - phase_start < PHASE_ROOTS) begin
            set_len = pick_set_len();
            for (int k = 1; k <= set_len; k++)
               send_root(pick_root(), k == set_len, 1'b1);
         end
         // hold off new roots until the row has drained
         drain_expected();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
